// ===== rtl/core/dgsc_pkg.sv =====
`timescale 1ns / 1ps
package dgsc_pkg;
    localparam int CHANNELS = 4;
    localparam int SAMPLES_PER_SUM = 4;
    localparam int ROUNDS_PER_CALC = 4;
    localparam int SLOPE_SHIFT = 14;
    localparam int CUPS = 3;
    localparam int WORDS_PER_CHANNEL = 6;
    localparam int X_WORDS = CUPS * CHANNELS * WORDS_PER_CHANNEL;
    localparam int TABLE_WORDS = X_WORDS + 4;
    localparam int TAB_AW = 7;
    localparam int SMP_AW = 4;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CAL = 2'd1;
    localparam logic [1:0] CMD_CUP = 2'd2;

    localparam logic [1:0] REG_SIGNAL_LIMIT = 2'd0;
    localparam logic [1:0] REG_SLOPE_LIMIT = 2'd1;
    localparam logic [1:0] REG_RESULT_MAX = 2'd2;
    localparam logic [1:0] REG_RESULT_MIN = 2'd3;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_LARGE = 3'd1;
    localparam logic [2:0] ERR_CAL = 3'd2;
    localparam logic [2:0] ERR_MAX = 3'd3;
    localparam logic [2:0] ERR_MIN = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLEAR, ST_SUM, ST_SUMW, ST_XRD, ST_XW, ST_Y, ST_YW,
        ST_SEL, ST_CHK, ST_DIV, ST_MUL, ST_RES, ST_OUT
    } state_t;
endpackage

// ===== rtl/core/dual_gain_sensor_calibrator_top.sv =====
`timescale 1ns / 1ps
// dual gain sensor calibrator
// s_axis requests carry a command in tuser: sample tick, calibration word
// write or cup select. m_axis delivers one result per channel on every
// fourth completed round of four channels, tlast on channel 3.
// a calibration write, an unchanged cup select or a sample tick that does
// not complete a calculating round leaves the block idle, so such requests
// can follow back to back. a cup change runs a sample clear of all sixteen
// sample memory words, and no request is taken meanwhile. after reset a
// clearing pass that sweeps the 76 calibration table words zeroes the
// sample memory and the table. no request is taken meanwhile.
// the sample tick that completes a calculating round starts four channel
// calculations one after another; each channel reads samples, then x/y
// points, runs the checks, runs a bit-serial restoring divider that yields
// a 34 bit quotient, then the multiply, result and output steps; a failed
// check goes straight to output. no request is taken until the last
// channel's result is registered.
// results wait in an output register; a stalled receiver holds the next
// channel's calculation until the result is taken. samples and calibration
// words are held in a sample memory and a calibration memory with registered reads.
module dual_gain_sensor_calibrator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // adc_high_gain, adc_low_gain, cal_index, cal_value, cup_select
    input  logic [1:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // cup, channel, value, error_code, low_gain_used
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import dgsc_pkg::*;

    logic [13:0] sig_lim_reg;
    logic [19:0] slope_lim_reg;
    logic [15:0] rmax_reg, rmin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_lim_reg <= 14'd3200;
            slope_lim_reg <= 20'd300000;
            rmax_reg <= 16'd32000;
            rmin_reg <= 16'd320;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SIGNAL_LIMIT: sig_lim_reg <= cfg_data[13:0];
                REG_SLOPE_LIMIT:  slope_lim_reg <= cfg_data;
                REG_RESULT_MAX:   rmax_reg <= cfg_data[15:0];
                REG_RESULT_MIN:   rmin_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [11:0] in_hi, in_lo;
    logic [6:0]  in_idx;
    logic [15:0] in_val;
    logic [1:0]  in_cup;
    assign in_hi = s_tdata[11:0];
    assign in_lo = s_tdata[23:12];
    assign in_idx = s_tdata[30:24];
    assign in_val = s_tdata[46:31];
    assign in_cup = s_tdata[48:47];

    state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [1:0] ch_ctr_reg, slot_reg, rdiv_reg, cup_reg, calc_ch_reg;
    logic [3:0] flags_reg;
    logic [2:0] k_reg;
    logic init_reg;
    logic [13:0] hsum_reg, lsum_reg;
    logic [15:0] x_reg [6];
    logic [15:0] y_reg [4];
    logic fl_reg;
    logic [13:0] acc_reg;
    logic [15:0] xa_reg, xb_reg, ya_reg, yb_reg;
    logic [2:0] err_reg;
    logic [33:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0] dcnt_reg;
    logic signed [47:0] prod_reg;
    logic [23:0] mdata_reg;
    logic mvalid_reg, mlast_reg;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !init_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata = mdata_reg;
    assign m_tlast = mlast_reg;

    // sample memory: hi in [11:0], lo in [23:12], addr ch*4+slot
    logic smp_we;
    logic [3:0] smp_wa, smp_ra;
    logic [23:0] smp_wd, smp_rd;
    dgsc_ram #(.WIDTH(24), .DEPTH(16)) u_smp (
        .aclk(aclk), .we(smp_we), .waddr(smp_wa), .wdata(smp_wd),
        .raddr(smp_ra), .rdata(smp_rd)
    );
    logic tab_we;
    logic [6:0] tab_wa, tab_ra;
    logic [15:0] tab_wd, tab_rd;
    dgsc_ram #(.WIDTH(16), .DEPTH(128)) u_tab (
        .aclk(aclk), .we(tab_we), .waddr(tab_wa), .wdata(tab_wd),
        .raddr(tab_ra), .rdata(tab_rd)
    );

    logic [1:0] sel_cup;
    assign sel_cup = (in_cup >= 2'(CUPS)) ? 2'd0 : in_cup;

    logic [6:0] xbase;
    assign xbase = 7'(cup_reg * (CHANNELS * WORDS_PER_CHANNEL) + calc_ch_reg * WORDS_PER_CHANNEL);

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == CMD_SAMPLE && ch_ctr_reg == 2'd3 && rdiv_reg == 2'd3) begin
                    state_next = ST_SUM;
                    cnt_next = '0;
                end else if (s_fire && s_tuser == CMD_CUP && sel_cup != cup_reg) begin
                    state_next = ST_CLEAR;
                    cnt_next = '0;
                end
            end
            ST_CLEAR: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd15) state_next = ST_IDLE;
            end
            ST_SUM: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd3) state_next = ST_SUMW;
            end
            ST_SUMW: begin
                state_next = ST_XRD;
                cnt_next = '0;
            end
            ST_XRD: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd5) state_next = ST_XW;
            end
            ST_XW: begin
                state_next = ST_Y;
                cnt_next = '0;
            end
            ST_Y: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd3) state_next = ST_YW;
            end
            ST_YW: state_next = ST_SEL;
            ST_SEL: state_next = ST_CHK;
            ST_CHK: state_next = (err_reg != ERR_OK) ? ST_OUT : ST_DIV;
            ST_DIV: if (dcnt_reg == 6'd1) state_next = ST_MUL;
            ST_MUL: state_next = ST_RES;
            ST_RES: state_next = ST_OUT;
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cnt_next = '0;
                    state_next = (calc_ch_reg == 2'd3) ? ST_IDLE : ST_SUM;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        smp_we = 1'b0;
        smp_wa = {ch_ctr_reg, slot_reg};
        smp_wd = {in_lo, in_hi};
        smp_ra = {calc_ch_reg, cnt_reg[1:0]};
        tab_we = 1'b0;
        tab_wa = in_idx;
        tab_wd = in_val;
        tab_ra = (state_reg == ST_Y) ? 7'(X_WORDS + 32'(cnt_reg[1:0]))
                                     : xbase + cnt_reg;
        if (state_reg == ST_CLEAR || init_reg) begin
            smp_we = 1'b1;
            smp_wa = cnt_reg[3:0];
            smp_wd = '0;
        end else if (s_fire && s_tuser == CMD_SAMPLE) begin
            smp_we = 1'b1;
        end
        if (init_reg) begin
            tab_we = 1'b1;
            tab_wa = cnt_reg;
            tab_wd = '0;
        end else if (s_fire && s_tuser == CMD_CAL && in_idx < 7'(TABLE_WORDS)) begin
            tab_we = 1'b1;
        end
    end

    // selection / checks
    logic nfl;
    logic [15:0] lo16, hi16;
    assign lo16 = {2'b0, lsum_reg};
    assign hi16 = {2'b0, hsum_reg};
    always_comb begin
        if (flags_reg[calc_ch_reg]) nfl = !(lo16 < x_reg[2]);
        else                        nfl = lo16 > x_reg[1];
    end

    logic signed [16:0] diff;
    assign diff = $signed({3'b0, acc_reg}) - $signed({1'b0, xb_reg});
    // slope fits 20 bits whenever it passes the limit check
    logic signed [20:0] slope_s;
    logic signed [37:0] prod_w;
    assign slope_s = $signed({1'b0, quo_reg[19:0]});
    assign prod_w = slope_s * diff;
    logic signed [48:0] r_full;
    assign r_full = 49'(prod_reg >>> SLOPE_SHIFT)
        + ((prod_reg < 0 && prod_reg[SLOPE_SHIFT-1:0] != '0) ? 49'sd1 : 49'sd0)
        + $signed({33'b0, yb_reg});
    logic [16:0] trial;
    assign trial = {rem_reg[15:0], quo_reg[33]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            init_reg <= 1'b1;
            ch_ctr_reg <= '0;
            slot_reg <= '0;
            rdiv_reg <= '0;
            cup_reg <= '0;
            flags_reg <= '1;
            calc_ch_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (init_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(TABLE_WORDS - 1)) begin
                    init_reg <= 1'b0;
                    cnt_reg <= '0;
                end
            end else begin
                state_reg <= state_next;
                cnt_reg <= cnt_next;
            end
            if (mvalid_reg && m_tready) mvalid_reg <= 1'b0;
            if (s_fire && s_tuser == CMD_SAMPLE) begin
                ch_ctr_reg <= ch_ctr_reg + 2'd1;
                if (ch_ctr_reg == 2'd3) begin
                    slot_reg <= slot_reg + 2'd1;
                    rdiv_reg <= rdiv_reg + 2'd1;
                    calc_ch_reg <= '0;
                end
            end
            if (s_fire && s_tuser == CMD_CUP && sel_cup != cup_reg) begin
                cup_reg <= sel_cup;
                flags_reg <= '1;
            end
            case (state_reg)
                ST_SEL: flags_reg[calc_ch_reg] <= nfl;
                ST_OUT: begin
                    if (!mvalid_reg || m_tready) begin
                        mvalid_reg <= 1'b1;
                        mlast_reg <= (calc_ch_reg == 2'd3);
                        mdata_reg <= {fl_reg, err_reg,
                                      (err_reg == ERR_OK) ? yb_reg : 16'hFFFF,
                                      calc_ch_reg, cup_reg};
                        calc_ch_reg <= calc_ch_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_SUM: begin
                if (cnt_reg == 7'd0) begin
                    hsum_reg <= '0;
                    lsum_reg <= '0;
                end else begin
                    hsum_reg <= hsum_reg + 14'(smp_rd[11:0]);
                    lsum_reg <= lsum_reg + 14'(smp_rd[23:12]);
                end
            end
            ST_SUMW: begin
                hsum_reg <= hsum_reg + 14'(smp_rd[11:0]);
                lsum_reg <= lsum_reg + 14'(smp_rd[23:12]);
            end
            ST_XRD: if (cnt_reg != 7'd0) x_reg[cnt_reg[2:0] - 3'd1] <= tab_rd;
            ST_XW: x_reg[5] <= tab_rd;
            ST_Y: if (cnt_reg != 7'd0) y_reg[cnt_reg[1:0] - 2'd1] <= tab_rd;
            ST_YW: y_reg[3] <= tab_rd;
            ST_SEL: begin
                fl_reg <= nfl;
                if (nfl) begin
                    acc_reg <= lsum_reg;
                    if (lo16 > x_reg[1]) begin
                        xa_reg <= x_reg[0]; xb_reg <= x_reg[1];
                        ya_reg <= y_reg[0]; yb_reg <= y_reg[1];
                    end else begin
                        xa_reg <= x_reg[1]; xb_reg <= x_reg[2];
                        ya_reg <= y_reg[1]; yb_reg <= y_reg[2];
                    end
                end else begin
                    acc_reg <= hsum_reg;
                    if (hi16 >= x_reg[4]) begin
                        xa_reg <= x_reg[3]; xb_reg <= x_reg[4];
                        ya_reg <= y_reg[1]; yb_reg <= y_reg[2];
                    end else begin
                        xa_reg <= x_reg[4]; xb_reg <= x_reg[5];
                        ya_reg <= y_reg[2]; yb_reg <= y_reg[3];
                    end
                end
                err_reg <= ERR_OK;
            end
            ST_CHK: begin
                if (acc_reg > sig_lim_reg) err_reg <= ERR_LARGE;
                else if (xa_reg <= xb_reg || ya_reg <= yb_reg) err_reg <= ERR_CAL;
                quo_reg <= {4'b0, ya_reg - yb_reg, 14'b0};
                rem_reg <= '0;
                dcnt_reg <= 6'd34;
            end
            ST_DIV: begin
                if (trial >= {1'b0, xa_reg - xb_reg}) begin
                    rem_reg <= trial - {1'b0, xa_reg - xb_reg};
                    quo_reg <= {quo_reg[32:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[32:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 6'd1;
            end
            ST_MUL: begin
                if (err_reg == ERR_OK && quo_reg > {14'b0, slope_lim_reg}) err_reg <= ERR_CAL;
                prod_reg <= 48'(prod_w);
            end
            ST_RES: begin
                if (err_reg == ERR_OK) begin
                    if (r_full > $signed({33'b0, rmax_reg})) err_reg <= ERR_MAX;
                    else if (r_full < -$signed({33'b0, rmin_reg})) err_reg <= ERR_MIN;
                    else yb_reg <= r_full[48] ? 16'd0 : r_full[15:0];
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/core/dgsc_ram.sv =====
`timescale 1ns / 1ps
module dgsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// ===== tb/dgsc_checker.sv =====
`timescale 1ns / 1ps
module dgsc_checker
    import dgsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,  // adc_high_gain, adc_low_gain, cal_index, cal_value, cup_select
    input  logic [1:0]  s_tuser,  // command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,  // cup, channel, value, error_code, low_gain_used
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output int          mismatches,
    output int          pending
);
    typedef struct packed {
        logic [1:0]  cup;
        logic [1:0]  chan;
        logic [15:0] value;
        logic [2:0]  err;
        logic        low_gain;
        logic        last;
    } calib_result_t;

    localparam longint SCALE = 64'd1 << SLOPE_SHIFT;

    calib_result_t calib_q[$];

    logic [11:0] hg_mem [CHANNELS][SAMPLES_PER_SUM];
    logic [11:0] lg_mem [CHANNELS][SAMPLES_PER_SUM];
    logic [15:0] cal_tab [TABLE_WORDS];
    bit          big_flag [CHANNELS];
    int          slot, chan_cnt, round_cnt, cup_now;
    longint      lim_signal, lim_slope, lim_max, lim_min;

    assign pending = calib_q.size();

    task automatic report(string what, longint got, longint want);
        $display("%0t %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic clear_store();
        for (int c = 0; c < CHANNELS; c++) begin
            big_flag[c] = 1'b1;
            for (int k = 0; k < SAMPLES_PER_SUM; k++) begin
                hg_mem[c][k] = '0;
                lg_mem[c][k] = '0;
            end
        end
    endtask

    function automatic calib_result_t calibrate(int ch);
        longint hi, lo, acc, xa, xb, ya, yb, slope, r;
        longint x [6];
        longint y [4];
        int base;
        calib_result_t o;
        hi = 0;
        lo = 0;
        for (int k = 0; k < SAMPLES_PER_SUM; k++) begin
            hi += longint'(hg_mem[ch][k]);
            lo += longint'(lg_mem[ch][k]);
        end
        base = cup_now * CHANNELS * WORDS_PER_CHANNEL + ch * WORDS_PER_CHANNEL;
        for (int i = 0; i < 6; i++) x[i] = longint'(cal_tab[base + i]);
        for (int i = 0; i < 4; i++) y[i] = longint'(cal_tab[X_WORDS + i]);
        if (big_flag[ch]) begin
            if (lo < x[2]) big_flag[ch] = 1'b0;
        end else begin
            if (lo > x[1]) big_flag[ch] = 1'b1;
        end
        if (big_flag[ch]) begin
            acc = lo;
            if (lo > x[1]) begin
                xa = x[0]; xb = x[1]; ya = y[0]; yb = y[1];
            end else begin
                xa = x[1]; xb = x[2]; ya = y[1]; yb = y[2];
            end
        end else begin
            acc = hi;
            if (hi >= x[4]) begin
                xa = x[3]; xb = x[4]; ya = y[1]; yb = y[2];
            end else begin
                xa = x[4]; xb = x[5]; ya = y[2]; yb = y[3];
            end
        end
        o.value = 16'hFFFF;
        o.err = ERR_OK;
        if (acc > lim_signal) begin
            o.err = ERR_LARGE;
        end else if (xa <= xb || ya <= yb) begin
            o.err = ERR_CAL;
        end else begin
            slope = ((ya - yb) * SCALE) / (xa - xb);
            if (slope > lim_slope) begin
                o.err = ERR_CAL;
            end else begin
                r = (slope * (acc - xb)) / SCALE + yb;
                if (r > lim_max) o.err = ERR_MAX;
                else if (r < -lim_min) o.err = ERR_MIN;
                else o.value = (r < 0) ? 16'd0 : r[15:0];
            end
        end
        o.cup = cup_now[1:0];
        o.chan = ch[1:0];
        o.low_gain = big_flag[ch];
        o.last = (ch == CHANNELS - 1);
        return o;
    endfunction

    task automatic take_request(logic [1:0] cmd, logic [55:0] d);
        int c, idx;
        case (cmd)
            CMD_CAL: begin
                idx = int'(d[30:24]);
                if (idx < TABLE_WORDS) cal_tab[idx] = d[46:31];
            end
            CMD_CUP: begin
                c = int'(d[48:47]);
                if (c >= CUPS) c = 0;
                if (c != cup_now) begin
                    cup_now = c;
                    clear_store();
                end
            end
            CMD_SAMPLE: begin
                hg_mem[chan_cnt][slot] = d[11:0];
                lg_mem[chan_cnt][slot] = d[23:12];
                if (chan_cnt + 1 < CHANNELS) begin
                    chan_cnt++;
                end else begin
                    chan_cnt = 0;
                    slot = (slot + 1) % SAMPLES_PER_SUM;
                    round_cnt = (round_cnt + 1) % ROUNDS_PER_CALC;
                    if (round_cnt == 0)
                        for (int k = 0; k < CHANNELS; k++) calib_q.push_back(calibrate(k));
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        calib_result_t want;
        if (calib_q.size() == 0) begin
            report("result with none expected", longint'(m_tdata), 0);
        end else begin
            want = calib_q.pop_front();
            if (m_tdata[1:0] != want.cup)
                report("cup", longint'(m_tdata[1:0]), longint'(want.cup));
            if (m_tdata[3:2] != want.chan)
                report("channel", longint'(m_tdata[3:2]), longint'(want.chan));
            if (m_tdata[19:4] != want.value)
                report("value", longint'(m_tdata[19:4]), longint'(want.value));
            if (m_tdata[22:20] != want.err)
                report("error code", longint'(m_tdata[22:20]), longint'(want.err));
            if (m_tdata[23] != want.low_gain)
                report("low gain", longint'(m_tdata[23]), longint'(want.low_gain));
            if (m_tlast != want.last)
                report("last", longint'(m_tlast), longint'(want.last));
        end
    endtask

    initial mismatches = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            lim_signal = 3200;
            lim_slope = 300000;
            lim_max = 32000;
            lim_min = 320;
            clear_store();
            slot = 0;
            chan_cnt = 0;
            round_cnt = 0;
            cup_now = 0;
            for (int i = 0; i < TABLE_WORDS; i++) cal_tab[i] = '0;
            calib_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SIGNAL_LIMIT: lim_signal = longint'(cfg_data[13:0]);
                    REG_SLOPE_LIMIT:  lim_slope = longint'(cfg_data);
                    REG_RESULT_MAX:   lim_max = longint'(cfg_data[15:0]);
                    REG_RESULT_MIN:   lim_min = longint'(cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) take_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) check_result();
        end
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import dgsc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;
    int          mismatches, pending;
    int          stuck_cycles = 0;
    int          ticks_in_phase, items_in_phase, level;
    bit          quiet = 1'b0;

    dual_gain_sensor_calibrator_top DUT (.*);

    dgsc_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) m_tready <= quiet || ($urandom_range(99) >= 35);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles > 20000) begin
            $display("dual_gain_sensor_calibrator_top: mismatch");
            $finish;
        end
    end

    task automatic send(logic [1:0] cmd, logic [11:0] hg, logic [11:0] lg, logic [6:0] idx,
                        logic [15:0] val, logic [1:0] cup);
        bit ready_seen;
        while (!quiet && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, cup, val, idx, lg, hg};
        forever begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
            if (ready_seen) break;
        end
    endtask

    task automatic sample(logic [11:0] hg, logic [11:0] lg);
        send(CMD_SAMPLE, hg, lg, 7'($urandom), 16'($urandom), 2'($urandom));
        ticks_in_phase++;
    endtask

    task automatic cal_write(int idx, int val);
        send(CMD_CAL, 12'($urandom), 12'($urandom), idx[6:0], val[15:0], 2'($urandom));
    endtask

    // descending x points within each three-point segment of a channel and, with with_y, descending y points
    task automatic load_table(int cup, bit with_y);
        int x, y;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int seg = 0; seg < 2; seg++) begin
                x = $urandom_range(9000, 16000);
                for (int k = 0; k < 3; k++) begin
                    cal_write(cup * CHANNELS * WORDS_PER_CHANNEL + ch * WORDS_PER_CHANNEL
                              + seg * 3 + k, x);
                    x -= $urandom_range(500, 4000);
                end
            end
        end
        if (with_y) begin
            y = $urandom_range(40000, 60000);
            for (int k = 0; k < 4; k++) begin
                cal_write(X_WORDS + k, y);
                y -= $urandom_range(2000, 12000);
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[19:0];
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(99);
        if (r < 72) begin
            if (ticks_in_phase % 4 == 0) level = $urandom_range(0, 4095);
            if ($urandom_range(1)) sample(12'($urandom), 12'($urandom));
            else sample(12'(level + $urandom_range(0, 200) - 100),
                        12'(level + $urandom_range(0, 200) - 100));
        end else if (r < 87) begin
            cal_write($urandom_range(0, TABLE_WORDS - 1), $urandom);
        end else if (r < 95) begin
            send(CMD_CUP, 12'($urandom), 12'($urandom), 7'($urandom), 16'($urandom),
                 2'($urandom_range(0, 3)));
        end else begin
            send(CMD_UNUSED, 12'($urandom), 12'($urandom), 7'($urandom), 16'($urandom),
                 2'($urandom));
        end
        items_in_phase++;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        ticks_in_phase = 0;
        load_table(0, 1'b1);
        send(CMD_UNUSED, 12'hFFF, 12'hFFF, 7'h7F, 16'hFFFF, 2'd3);
        cal_write(127, 'hFFFF);
        cal_write(TABLE_WORDS, 'h1234);
        send(CMD_CUP, '0, '0, '0, '0, 2'd3);
        send(CMD_CUP, '0, '0, '0, '0, 2'd0);
        for (int i = 0; i < 16; i++) begin
            if (i % 2 == 0) sample(12'hFFF, 12'hFFF);
            else sample(12'd0, 12'd0);
        end
        send(CMD_CUP, '0, '0, '0, '0, 2'd2);
        load_table(2, 1'b0);
        send(CMD_CUP, '0, '0, '0, '0, 2'd1);
        load_table(1, 1'b0);

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            case (p)
                0: begin
                    write_reg(REG_SIGNAL_LIMIT, 3200);
                    write_reg(REG_SLOPE_LIMIT, 300000);
                    write_reg(REG_RESULT_MAX, 32000);
                    write_reg(REG_RESULT_MIN, 320);
                end
                1: begin
                    write_reg(REG_SIGNAL_LIMIT, 16380);
                    write_reg(REG_SLOPE_LIMIT, 1048575);
                    write_reg(REG_RESULT_MAX, 65535);
                    write_reg(REG_RESULT_MIN, 65535);
                end
                2: begin
                    write_reg(REG_SIGNAL_LIMIT, 0);
                    write_reg(REG_SLOPE_LIMIT, 0);
                    write_reg(REG_RESULT_MAX, 0);
                    write_reg(REG_RESULT_MIN, 0);
                end
                default: begin
                    write_reg(REG_SIGNAL_LIMIT, $urandom_range(2000, 16380));
                    write_reg(REG_SLOPE_LIMIT, $urandom_range(50000, 400000));
                    write_reg(REG_RESULT_MAX, $urandom_range(0, 65535));
                    write_reg(REG_RESULT_MIN, $urandom_range(0, 2000));
                end
            endcase
            cfg_we <= 1'b0;
            quiet = (p == 2);
            ticks_in_phase = 0;
            items_in_phase = 0;
            while (items_in_phase < 24 || ticks_in_phase < 20) random_request();
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0) $display("dual_gain_sensor_calibrator_top: match");
        else $display("dual_gain_sensor_calibrator_top: mismatch");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/dgsc_pkg.sv
rtl/core/dgsc_ram.sv
rtl/core/dual_gain_sensor_calibrator_top.sv
tb/dgsc_checker.sv
tb/tb.sv
